// File: rtl/chm_pkg.sv
// Shared types and constants for the cache hit/miss model.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package chm_pkg;

   localparam int ADDR_W     = 31;
   localparam int BLK_W      = 31;
   localparam int TOTAL_W    = 32;
   localparam int MODE_W     = 2;
   localparam int BSL_W      = 5;
   localparam int LL_W       = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [MODE_W-1:0] MODE_TWO_WAY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FULL    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE            = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE_LOG2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES_LOG2      = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
   localparam logic [BSL_W-1:0]  BSL_RESET  = 5'd4;
   localparam logic [LL_W-1:0]   LL_RESET   = 3'd6;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic compare;
      logic scan_step;
      logic update;
      logic finish;
   } chm_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic full_mode;
      logic scan_done;
   } chm_sts_type;

endpackage

// File: rtl/chm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module chm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/chm_ctrl.sv
// Controller state machine for the cache hit/miss model.
// Depends on chm_pkg for the command and status structs.
`timescale 1ns / 1ps

module chm_ctrl import chm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output chm_cmd_type cmd,
   input  chm_sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_UPD   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.full_mode ? S_SCAN : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A new result may be loaded in the same cycle as the old one transfers.
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/chm_dp.sv
// Datapath of the cache hit/miss model: configuration, block stores, use counters,
// the set index mask, the associative scan and the result registers.
// Depends on chm_pkg and chm_ram.
`timescale 1ns / 1ps

module chm_dp import chm_pkg::*; #(
   parameter int MAX_LINES   = 64,
   parameter int COUNT_LIMIT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [ADDR_W-1:0]     req_address,
   input  chm_cmd_type           cmd,
   output chm_sts_type           sts,
   output logic                  rsp_hit,
   output logic [TOTAL_W-1:0]    rsp_access_total,
   output logic [TOTAL_W-1:0]    rsp_miss_total
);

   localparam int LW      = $clog2(MAX_LINES + 1);
   localparam int AW      = $clog2(MAX_LINES);
   localparam int DEPTH_B = (MAX_LINES + 1) / 2;
   localparam int BAW     = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
   localparam int CW      = $clog2(COUNT_LIMIT + 1);
   localparam int WW      = BLK_W + 1;

   // Configuration registers.
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [BSL_W-1:0]  bsl_ff, bsl_in;
   logic [LL_W-1:0]   ll_ff, ll_in;

   // Per-item registers.
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic [LW-1:0]        rem_ff, rem_in;
   logic [LW-1:0]        scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [AW-1:0]        chk_idx_ff, chk_idx_in;
   logic [CW-1:0]        low_ff, low_in;
   logic [AW-1:0]        pick_ff, pick_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        match_idx_ff, match_idx_in;
   logic [CW-1:0]        match_cnt_ff, match_cnt_in;
   logic                 hit_ff, hit_in;
   logic [AW-1:0]        clr_ff, clr_in;

   // Result registers; the totals double as the running counters.
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [TOTAL_W-1:0]   acc_ff, acc_in;
   logic [TOTAL_W-1:0]   miss_ff, miss_in;

   // Memory ports.
   logic          a_we, b_we, u_we;
   logic [AW-1:0] a_waddr, a_raddr, u_waddr, u_raddr;
   logic [BAW-1:0] b_waddr, b_raddr;
   logic [WW-1:0] a_wdata, a_rdata, b_wdata, b_rdata;
   logic [CW-1:0] u_wdata, u_rdata;

   logic          is_two, is_full;
   logic [7:0]    pow2;
   logic [LW-1:0] lines, sets;
   logic [LW-1:0] idx_mask;
   logic          issue;
   logic          entry_match;
   logic          hit_a, hit_b, hit_cmp;
   logic [CW-1:0] cnt_inc;
   logic          clr_in_b;

   assign is_two = (mode_ff == MODE_TWO_WAY);
   assign is_full = (mode_ff == MODE_FULL);

   // Line count is 2^lines_log2 capped at the store depth; two-way uses half of it.
   assign pow2 = 8'd1 << ll_ff;
   always_comb begin
      if (32'(pow2) > 32'(MAX_LINES)) begin
         lines = LW'(MAX_LINES);
      end else begin
         lines = LW'(pow2);
      end
      sets = lines >> 1;
      if (sets == '0) begin
         sets = LW'(1);
      end
   end

   always_comb begin
      mode_in = mode_ff;
      bsl_in  = bsl_ff;
      ll_in   = ll_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:            mode_in = csr_wdata[MODE_W-1:0];
            CSR_BLOCK_SIZE_LOG2: bsl_in  = csr_wdata[BSL_W-1:0];
            CSR_LINES_LOG2:      ll_in   = csr_wdata[LL_W-1:0];
            default: ;
         endcase
      end
   end

   // Line and set counts are powers of two, so the index is the low block-number bits.
   assign idx_mask = (is_two ? sets : lines) - LW'(1);

   assign issue       = (scan_ff < lines);
   assign entry_match = a_rdata[BLK_W] && (a_rdata[BLK_W-1:0] == blk_ff);
   assign hit_a       = entry_match;
   assign hit_b       = b_rdata[BLK_W] && (b_rdata[BLK_W-1:0] == blk_ff);
   assign hit_cmp     = hit_a || (is_two && hit_b);
   assign cnt_inc     = (match_cnt_ff < CW'(COUNT_LIMIT)) ? match_cnt_ff + CW'(1)
                                                          : match_cnt_ff;
   assign clr_in_b    = (32'(clr_ff) < 32'(DEPTH_B));

   always_comb begin
      blk_in       = blk_ff;
      rem_in       = rem_ff;
      scan_in      = scan_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      low_in       = low_ff;
      pick_in      = pick_ff;
      found_in     = found_ff;
      match_idx_in = match_idx_ff;
      match_cnt_in = match_cnt_ff;
      hit_in       = hit_ff;
      if (cmd.load) begin
         blk_in     = req_address >> bsl_ff;
         rem_in     = blk_in[LW-1:0] & idx_mask;
         scan_in    = '0;
         chk_vld_in = 1'b0;
         low_in     = CW'(COUNT_LIMIT);
         pick_in    = '0;
         found_in   = 1'b0;
      end
      if (cmd.scan_step) begin
         chk_vld_in = issue;
         chk_idx_in = scan_ff[AW-1:0];
         if (issue) begin
            scan_in = scan_ff + LW'(1);
         end
         // Read data arrives in the cycle after its index is issued.
         if (chk_vld_ff) begin
            if (!found_ff && entry_match) begin
               found_in     = 1'b1;
               match_idx_in = chk_idx_ff;
               match_cnt_in = u_rdata;
            end
            if (u_rdata < low_ff) begin
               low_in  = u_rdata;
               pick_in = chk_idx_ff;
            end
         end
      end
      if (cmd.compare) begin
         hit_in = hit_cmp;
      end
      if (cmd.update) begin
         hit_in = found_ff;
      end
   end

   always_comb begin
      clr_in     = cmd.clear_step ? clr_ff + AW'(1) : clr_ff;
      rsp_hit_in = rsp_hit_ff;
      acc_in     = acc_ff;
      miss_in    = miss_ff;
      if (cmd.finish) begin
         rsp_hit_in = hit_ff;
         acc_in     = acc_ff + TOTAL_W'(1);
         miss_in    = miss_ff + TOTAL_W'(!hit_ff);
      end
   end

   always_comb begin
      a_we    = 1'b0;
      a_waddr = rem_ff[AW-1:0];
      a_wdata = {1'b1, blk_ff};
      b_we    = 1'b0;
      b_waddr = rem_ff[BAW-1:0];
      b_wdata = a_rdata;
      u_we    = 1'b0;
      u_waddr = pick_ff;
      u_wdata = '0;
      priority if (cmd.clear_step) begin
         a_we    = 1'b1;
         a_waddr = clr_ff;
         a_wdata = '0;
         b_we    = clr_in_b;
         b_waddr = clr_ff[BAW-1:0];
         b_wdata = '0;
         u_we    = 1'b1;
         u_waddr = clr_ff;
      end else if (cmd.compare) begin
         // A two-way miss pushes way 0, valid bit included, into way 1.
         a_we = !hit_cmp;
         b_we = !hit_cmp && is_two;
      end else if (cmd.update) begin
         a_we    = !found_ff;
         a_waddr = pick_ff;
         u_we    = 1'b1;
         u_waddr = found_ff ? match_idx_ff : pick_ff;
         u_wdata = found_ff ? cnt_inc : '0;
      end else begin
         a_we = 1'b0;
      end
   end

   assign a_raddr = cmd.scan_step ? scan_ff[AW-1:0] : rem_ff[AW-1:0];
   assign b_raddr = rem_ff[BAW-1:0];
   assign u_raddr = scan_ff[AW-1:0];

   chm_ram #(.WIDTH(WW), .DEPTH(MAX_LINES)) u_store_a (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (a_wdata),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   chm_ram #(.WIDTH(WW), .DEPTH(DEPTH_B)) u_store_b (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   chm_ram #(.WIDTH(CW), .DEPTH(MAX_LINES)) u_use_count (
      .clock (clock),
      .we    (u_we),
      .waddr (u_waddr),
      .wdata (u_wdata),
      .raddr (u_raddr),
      .rdata (u_rdata)
   );

   assign sts.clear_last = (clr_ff == AW'(MAX_LINES - 1));
   assign sts.full_mode  = is_full;
   assign sts.scan_done  = found_ff || (!issue && !chk_vld_ff);

   assign rsp_hit          = rsp_hit_ff;
   assign rsp_access_total = acc_ff;
   assign rsp_miss_total   = miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         bsl_ff  <= BSL_RESET;
         ll_ff   <= LL_RESET;
         clr_ff  <= '0;
         acc_ff  <= '0;
         miss_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         bsl_ff  <= bsl_in;
         ll_ff   <= ll_in;
         clr_ff  <= clr_in;
         acc_ff  <= acc_in;
         miss_ff <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      rem_ff       <= rem_in;
      scan_ff      <= scan_in;
      chk_vld_ff   <= chk_vld_in;
      chk_idx_ff   <= chk_idx_in;
      low_ff       <= low_in;
      pick_ff      <= pick_in;
      found_ff     <= found_in;
      match_idx_ff <= match_idx_in;
      match_cnt_ff <= match_cnt_in;
      hit_ff       <= hit_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

endmodule

// File: rtl/cache_hit_miss_model.sv
// Top level of the cache hit/miss model: controller plus datapath.
// Depends on chm_pkg, chm_ctrl, chm_dp and chm_ram.
//
//   channel  ports                                      direction  handshake
//   req      req_address                                in         req_valid / req_ready
//   rsp      rsp_hit, rsp_access_total, rsp_miss_total  out        rsp_valid / rsp_ready
//   csr      csr_index, csr_wdata                       in         csr_we (no wait)
//
// For direct mapped and two-way items the set index is masked from the block number
// at the transfer, then come one memory read and one compare. Fully associative items
// make one pass over the entries through the registered read port of the block and
// use-count memories; a hit ends the pass early.
// After reset a clearing pass over all MAX_LINES entries holds req_ready low.
// A finished result waits in the output register while the next item proceeds.
`timescale 1ns / 1ps

module cache_hit_miss_model import chm_pkg::*; #(
   parameter int MAX_LINES   = 64,
   parameter int COUNT_LIMIT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADDR_W-1:0]     req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [TOTAL_W-1:0]    rsp_access_total,
   output logic [TOTAL_W-1:0]    rsp_miss_total,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   chm_cmd_type cmd;
   chm_sts_type sts;

   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   chm_dp #(
      .MAX_LINES   (MAX_LINES),
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_address      (req_address),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_hit          (rsp_hit),
      .rsp_access_total (rsp_access_total),
      .rsp_miss_total   (rsp_miss_total)
   );

endmodule

// File: rtl/chm_checker.sv
// Port-level checker for the cache hit/miss model, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module chm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_access_total,
   input logic [31:0] rsp_miss_total
);

   logic        req_xfer, rsp_xfer;
   logic [31:0] last_acc_ff, last_acc_in;
   logic [31:0] last_miss_ff, last_miss_in;
   logic [1:0]  pend_ff, pend_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      last_acc_in  = rsp_xfer ? rsp_access_total : last_acc_ff;
      last_miss_in = rsp_xfer ? rsp_miss_total : last_miss_ff;
      pend_in      = pend_ff + 2'(req_xfer) - 2'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_acc_ff  <= '0;
         last_miss_ff <= '0;
         pend_ff      <= '0;
      end else begin
         last_acc_ff  <= last_acc_in;
         last_miss_ff <= last_miss_in;
         pend_ff      <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_access_total) && $stable(rsp_miss_total))
      else $error("result changed while stalled");

   a_access_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> rsp_access_total == last_acc_ff + 32'd1)
      else $error("access total did not advance by one");

   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> rsp_miss_total == last_miss_ff + {31'd0, !rsp_hit})
      else $error("miss total does not match the hit flag");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ports active right after reset");

   a_outstanding: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3 && (!rsp_valid || pend_ff != 2'd0))
      else $error("result count does not match accepted items");

endmodule

bind cache_hit_miss_model chm_checker u_chm_checker (.*);

// File: bench/cache_hit_miss_model_tb.sv
// Self-checking testbench for cache_hit_miss_model: directed and random address traces
// across all cache organizations, checked against a hit/miss tracker class.
// Depends on chm_pkg and the RTL of cache_hit_miss_model.
`timescale 1ns / 1ps

module cache_hit_miss_model_tb;
   import chm_pkg::*;

   localparam int CACHE_LINES       = 64;
   localparam int CACHE_COUNT_LIMIT = 256;
   localparam int ITEM_TARGET       = 1900;
   localparam int IDLE_PCT          = 13;
   localparam int QUIET_FROM        = 1000;
   localparam int QUIET_TO          = 1300;
   localparam int HOLD_AT           = 100;
   localparam int HOLD_CYCLES       = 400;
   localparam int STALL_LIMIT       = 5000;
   localparam int TAIL_CYCLES       = 100;
   localparam int POOL_MAX          = 132;
   localparam int REPORT_LIMIT      = 10;

   localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

   typedef struct packed {
      logic               hit;
      logic [TOTAL_W-1:0] access_total;
      logic [TOTAL_W-1:0] miss_total;
   } access_outcome_type;

   // Tracks the cache contents and counters and holds the outcomes still owed.
   class hit_miss_tracker;
      logic [MODE_W-1:0]  mode;
      logic [BSL_W-1:0]   block_shift;
      logic [LL_W-1:0]    lines_log2;
      logic [BLK_W-1:0]   way0_block [CACHE_LINES];
      logic [BLK_W-1:0]   way1_block [CACHE_LINES/2];
      bit                 way0_valid [CACHE_LINES];
      bit                 way1_valid [CACHE_LINES/2];
      int unsigned        use_count  [CACHE_LINES];
      logic [TOTAL_W-1:0] accesses;
      logic [TOTAL_W-1:0] misses;
      access_outcome_type pending_outcomes [$];
      int                 errors;

      function new();
         mode        = MODE_RESET;
         block_shift = BSL_RESET;
         lines_log2  = LL_RESET;
         foreach (way0_block[i]) begin
            way0_block[i] = '0;
            way0_valid[i] = 1'b0;
            use_count[i]  = 0;
         end
         foreach (way1_block[i]) begin
            way1_block[i] = '0;
            way1_valid[i] = 1'b0;
         end
         accesses = '0;
         misses   = '0;
         errors   = 0;
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_MODE:            mode        = value[MODE_W-1:0];
            CSR_BLOCK_SIZE_LOG2: block_shift = value[BSL_W-1:0];
            CSR_LINES_LOG2:      lines_log2  = value[LL_W-1:0];
            default: ;
         endcase
      endfunction

      // Looks the block up in the current organization and fills it on a miss.
      function bit lookup_block(input logic [BLK_W-1:0] blk);
         int unsigned lines;
         int unsigned sets;
         int unsigned idx;
         int unsigned low;
         int unsigned pick;
         lines = 1 << lines_log2;
         if (lines > CACHE_LINES) lines = CACHE_LINES;
         if (mode == MODE_TWO_WAY) begin
            sets = lines / 2;
            if (sets == 0) sets = 1;
            idx = blk % sets;
            if ((way0_valid[idx] && way0_block[idx] == blk) ||
                (way1_valid[idx] && way1_block[idx] == blk)) return 1'b1;
            way1_block[idx] = way0_block[idx];
            way1_valid[idx] = way0_valid[idx];
            way0_block[idx] = blk;
            way0_valid[idx] = 1'b1;
            return 1'b0;
         end
         if (mode == MODE_FULL) begin
            for (int j = 0; j < lines; j++) begin
               if (way0_valid[j] && way0_block[j] == blk) begin
                  if (use_count[j] < CACHE_COUNT_LIMIT) use_count[j]++;
                  return 1'b1;
               end
            end
            // Saturated entries never win the victim search; entry 0 is the fallback.
            low  = CACHE_COUNT_LIMIT;
            pick = 0;
            for (int j = 0; j < lines; j++) begin
               if (use_count[j] < low) begin
                  low  = use_count[j];
                  pick = j;
               end
            end
            way0_block[pick] = blk;
            way0_valid[pick] = 1'b1;
            use_count[pick]  = 0;
            return 1'b0;
         end
         // The spare mode encoding behaves as direct mapped.
         idx = blk % lines;
         if (way0_valid[idx] && way0_block[idx] == blk) return 1'b1;
         way0_block[idx] = blk;
         way0_valid[idx] = 1'b1;
         return 1'b0;
      endfunction

      function void note_access(input logic [ADDR_W-1:0] addr);
         access_outcome_type outcome;
         outcome.hit = lookup_block(addr >> block_shift);
         accesses++;
         if (!outcome.hit) misses++;
         outcome.access_total = accesses;
         outcome.miss_total   = misses;
         pending_outcomes.push_back(outcome);
      endfunction

      function void report_error(input string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
      endfunction

      function void check_outcome(input logic hit, input logic [TOTAL_W-1:0] acc,
                                  input logic [TOTAL_W-1:0] miss);
         access_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            report_error($sformatf("result with no access outstanding: hit %0b acc %0d miss %0d",
                                   hit, acc, miss));
            return;
         end
         want = pending_outcomes.pop_front();
         if (hit !== want.hit)
            report_error($sformatf("access %0d hit: expected %0b, got %0b",
                                   want.access_total, want.hit, hit));
         if (acc !== want.access_total)
            report_error($sformatf("access_total: expected %0d, got %0d",
                                   want.access_total, acc));
         if (miss !== want.miss_total)
            report_error($sformatf("access %0d miss_total: expected %0d, got %0d",
                                   want.access_total, want.miss_total, miss));
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic                  rsp_hit;
   logic [TOTAL_W-1:0]    rsp_access_total;
   logic [TOTAL_W-1:0]    rsp_miss_total;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   hit_miss_tracker tracker;
   int              items_sent   = 0;
   int              results_seen = 0;

   cache_hit_miss_model #(
      .MAX_LINES   (CACHE_LINES),
      .COUNT_LIMIT (CACHE_COUNT_LIMIT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_access_total (rsp_access_total),
      .rsp_miss_total   (rsp_miss_total),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // Offers one address and returns once the transfer has happened.
   task automatic send_access(input logic [ADDR_W-1:0] addr);
      bit may_idle;
      may_idle = !(items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      while (may_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_access(addr);
      items_sent++;
   endtask

   task automatic send_list(input logic [ADDR_W-1:0] addrs [$]);
      foreach (addrs[i]) send_access(addrs[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic program_cache(input logic [MODE_W-1:0] m, input logic [BSL_W-1:0] shift,
                                input logic [LL_W-1:0] ll);
      logic [CSR_IDX_W-1:0]  idx [3];
      logic [CSR_DATA_W-1:0] val [3];
      idx = '{CSR_MODE, CSR_BLOCK_SIZE_LOG2, CSR_LINES_LOG2};
      val = '{CSR_DATA_W'(m), CSR_DATA_W'(shift), CSR_DATA_W'(ll)};
      foreach (idx[i]) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker.set_register(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Most addresses reuse a small set of blocks so that hits and evictions both occur.
   task automatic run_phase(input int n, input int pool_n, input int noise_pct);
      logic [ADDR_W-1:0] pool [POOL_MAX];
      logic [ADDR_W-1:0] offset_mask;
      logic [ADDR_W-1:0] addr;
      offset_mask = ADDR_W'((32'd1 << tracker.block_shift) - 32'd1);
      for (int k = 0; k < pool_n; k++)
         pool[k] = ($urandom_range(3) == 0) ?
                   ADDR_W'(ADDR_W'($urandom_range(7)) << tracker.block_shift) :
                   ADDR_W'($urandom);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < noise_pct)
            addr = ADDR_W'($urandom);
         else
            addr = (pool[$urandom_range(pool_n - 1)] & ~offset_mask) |
                   (ADDR_W'($urandom) & offset_mask);
         send_access(addr);
      end
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0] m;
      logic [BSL_W-1:0]  shift;
      logic [LL_W-1:0]   ll;
      int                pool_n;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: direct mapped, 16-unit blocks, 64 lines.
      send_list('{31'h0, 31'hF, 31'h10, 31'h400, 31'h0, 31'h7FFFFFFF, 31'h7FFFFFFF,
                  31'h55555555, 31'h2AAAAAAA});
      wait_drained();
      // Two-way with a single line still has one set.
      program_cache(MODE_TWO_WAY, 5'd8, 3'd0);
      send_list('{31'h0, 31'h100, 31'h0, 31'h200, 31'h100, 31'h7FFFFF00});
      wait_drained();
      // Spare mode, largest shift and a line count above the cap.
      program_cache(MODE_SPARE, 5'd31, 3'd7);
      send_list('{31'h12345678, 31'h7FFFFFFF});
      wait_drained();
      program_cache(MODE_FULL, 5'd0, 3'd7);
      send_list('{31'h7FFFFFFF, 31'h1, 31'h1, 31'h7FFFFFFF, 31'h2});
      wait_drained();

      // Two entries hammered until their use counts saturate, then evictions.
      program_cache(MODE_FULL, 5'd2, 3'd1);
      run_phase(600, 2, 0);
      run_phase(40, 4, 30);
      wait_drained();
      program_cache(MODE_DIRECT, 5'd16, 3'd6);
      run_phase(60, 40, 10);

      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         m     = MODE_W'($urandom_range(3));
         shift = ($urandom_range(3) == 0) ? BSL_W'($urandom_range(16, 31)) :
                                            BSL_W'($urandom_range(0, 10));
         ll    = LL_W'($urandom_range(7));
         pool_n = $urandom_range(1, 2 * (1 << ((ll > 3'd6) ? 3'd6 : ll)) + 1);
         program_cache(m, shift, ll);
         run_phase($urandom_range(20, 120), pool_n, $urandom_range(5, 20));
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors + tracker.pending() == 0)
         $display("cache_hit_miss_model_tb: done, clean");
      else
         $display("cache_hit_miss_model_tb: done, errors");
      $finish;
   end

   // Result side: random stalls, one long hold-off that backs the block up, and a
   // stretch with ready held high.
   initial begin : result_side
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            tracker.check_outcome(rsp_hit, rsp_access_total, rsp_miss_total);
            results_seen++;
         end
         if (!held_once && results_seen == HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Ends the run if no transfer happens on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("cache_hit_miss_model_tb: done, errors");
      $finish;
   end

endmodule
